// ----- hw/rtl/csmf_pkg.sv -----
`default_nettype none

package csmf_pkg;

    localparam int unsigned HIST_DEPTH_DEF = 64;

    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned WINDOW_W   = 7;
    localparam int unsigned OFFSET_W   = 3;
    localparam int unsigned SECTOR_W   = 3;
    localparam int unsigned HEADING_W  = 10;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned NUM_SECTORS = 8;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;
    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 7'd64;
    localparam logic [OFFSET_W-1:0]   OFFSET_RESET   = 3'd3;

    typedef enum logic [1:0] {
        REG_INTERVAL = 2'd0,
        REG_WINDOW   = 2'd1,
        REG_OFFSET   = 2'd2
    } cfg_reg_t;

    // pin code {pin0, pin1, pin2} to compass sector
    localparam logic [SECTOR_W-1:0] DECODE_TAB [NUM_SECTORS] =
        '{3'd4, 3'd3, 3'd1, 3'd2, 3'd5, 3'd6, 3'd0, 3'd7};

    // sector centre in half degrees: sector*90+45
    localparam logic [HEADING_W-1:0] HEADING_TAB [NUM_SECTORS] =
        '{10'd45, 10'd135, 10'd225, 10'd315, 10'd405, 10'd495, 10'd585, 10'd675};

    // zero acts as one, anything above the history depth acts as the depth
    function automatic int unsigned clamp_len(input logic [WINDOW_W-1:0] wl,
                                              input int unsigned depth);
        int unsigned n;
        n = int'(wl);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > depth)
        begin
            n = depth;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/compass_sector_mode_filter.sv -----
// Compass sector mode filter. One tick transaction is taken per clock cycle, back to back
// unless stalled; when the elapsed tick count reaches interval_reg the tick samples the three
// pin levels and its result transaction goes to the output register, or to the skid register
// while one waits; ticks that do not sample give no result. Decoding, rotation, the history
// ring update, the per-sector count update and the eight-way mode search all happen between
// the input handshake and the output register. The sector history is a HIST_DEPTH-entry memory
// with one write port and one registered read port; the entry due to be overwritten by the next
// sample is read ahead every cycle, with write forwarding, so samples can follow every cycle.
// A fill count stands in for clearing the history, so there is no clearing pass after reset or
// after a window_len write, and the block takes ticks from the first cycle out of reset. A
// two-entry output (result register plus skid register) lets a tick be taken while a result
// waits; in_stall rises only when both hold results. Configuration writes are always ready.
`default_nettype none

module compass_sector_mode_filter
    import csmf_pkg::*;
#(
    parameter int unsigned HIST_DEPTH = HIST_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  pin0_level,
    input  wire logic                  pin1_level,
    input  wire logic                  pin2_level,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [SECTOR_W-1:0]        raw_sector,
    output logic [SECTOR_W-1:0]        filtered_sector,
    output logic [HEADING_W-1:0]       heading_half_deg,
    output logic [INTERVAL_W-1:0]      elapsed_ticks
);

    localparam int unsigned AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int unsigned LW = $clog2(HIST_DEPTH + 1);
    localparam logic [LW-1:0] RESET_LEN = LW'(clamp_len(WINDOW_RESET, HIST_DEPTH));

    function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p,
                                              input logic [LW-1:0] len);
        logic [LW-1:0] q;
        q = LW'(p) + LW'(1);
        pos_inc = (q >= len) ? '0 : q[AW-1:0];
    endfunction

    // configuration
    logic [INTERVAL_W-1:0] interval_reg;
    logic [WINDOW_W-1:0]   window_len_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic                  cfg_fire;
    logic                  win_write;
    logic [LW-1:0]         eff_len;
    logic [LW-1:0]         new_len;

    // window state
    logic [INTERVAL_W-1:0] tick_reg, tick_next;
    logic [AW-1:0]         wp_reg, wp_next, wp_new;
    logic [LW-1:0]         fill_reg, fill_next;
    logic [LW-1:0]         counts_reg  [NUM_SECTORS];
    logic [LW-1:0]         counts_next [NUM_SECTORS];
    logic [LW-1:0]         counts_upd  [NUM_SECTORS];
    logic [SECTOR_W-1:0]   hist_mem [HIST_DEPTH];
    logic [SECTOR_W-1:0]   old_rd_reg;
    logic [AW-1:0]         rd_addr;

    // per-tick logic
    logic                  in_fire;
    logic [INTERVAL_W:0]   tick_inc;
    logic [INTERVAL_W-1:0] elapsed;
    logic                  sample;
    logic [SECTOR_W-1:0]   sector;
    logic [SECTOR_W-1:0]   old_sector;
    logic [SECTOR_W-1:0]   best;
    logic [LW-1:0]         best_cnt;

    // output and skid registers
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [SECTOR_W-1:0]   out_raw_reg, skid_raw_reg;
    logic [SECTOR_W-1:0]   out_filt_reg, skid_filt_reg;
    logic [HEADING_W-1:0]  out_head_reg, skid_head_reg;
    logic [INTERVAL_W-1:0] out_elap_reg, skid_elap_reg;
    logic                  pop;
    logic                  load_out;
    logic                  load_skid;
    logic                  skid_to_out;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign win_write = cfg_fire && (cfg_index == REG_WINDOW);
    assign eff_len   = LW'(clamp_len(window_len_reg, HIST_DEPTH));
    assign new_len   = LW'(clamp_len(cfg_data[WINDOW_W-1:0], HIST_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= INTERVAL_RESET;
            window_len_reg <= WINDOW_RESET;
            offset_reg     <= OFFSET_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_INTERVAL: interval_reg   <= cfg_data[INTERVAL_W-1:0];
                REG_WINDOW:   window_len_reg <= cfg_data[WINDOW_W-1:0];
                REG_OFFSET:   offset_reg     <= cfg_data[OFFSET_W-1:0];
                default:      ;
            endcase
        end
    end

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid & ~in_stall;

    always_comb
    begin
        tick_inc = {1'b0, tick_reg} + {{INTERVAL_W{1'b0}}, 1'b1};
        elapsed  = tick_inc[INTERVAL_W] ? {INTERVAL_W{1'b1}} : tick_inc[INTERVAL_W-1:0];
        sample   = in_fire && (elapsed >= interval_reg);

        tick_next = tick_reg;
        if (in_fire)
        begin
            tick_next = sample ? '0 : elapsed;
        end
    end

    // decode, rotate, ring update and mode search
    always_comb
    begin
        sector = DECODE_TAB[{pin0_level, pin1_level, pin2_level}] + offset_reg;
        wp_new = pos_inc(wp_reg, eff_len);
        // entries not yet written since the last clear read as sector zero
        old_sector = (fill_reg >= eff_len) ? old_rd_reg : '0;

        for (int i = 0; i < NUM_SECTORS; i++)
        begin
            counts_upd[i] = counts_reg[i];
            if ((SECTOR_W'(i) == old_sector) && (counts_reg[i] != '0))
            begin
                counts_upd[i] = counts_upd[i] - LW'(1);
            end
            if (SECTOR_W'(i) == sector)
            begin
                counts_upd[i] = counts_upd[i] + LW'(1);
            end
        end

        best     = '0;
        best_cnt = counts_upd[0];
        for (int i = 1; i < NUM_SECTORS; i++)
        begin
            if (counts_upd[i] > best_cnt)
            begin
                best_cnt = counts_upd[i];
                best     = SECTOR_W'(i);
            end
        end

        wp_next   = wp_reg;
        fill_next = fill_reg;
        for (int i = 0; i < NUM_SECTORS; i++)
        begin
            counts_next[i] = counts_reg[i];
        end

        if (win_write)
        begin
            wp_next   = '0;
            fill_next = '0;
            for (int i = 0; i < NUM_SECTORS; i++)
            begin
                counts_next[i] = (i == 0) ? new_len : '0;
            end
        end
        else if (sample)
        begin
            wp_next = wp_new;
            if (fill_reg < eff_len)
            begin
                fill_next = fill_reg + LW'(1);
            end
            for (int i = 0; i < NUM_SECTORS; i++)
            begin
                counts_next[i] = counts_upd[i];
            end
        end

        rd_addr = pos_inc(wp_next, win_write ? new_len : eff_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            wp_reg   <= '0;
            fill_reg <= '0;
            for (int i = 0; i < NUM_SECTORS; i++)
            begin
                counts_reg[i] <= (i == 0) ? RESET_LEN : '0;
            end
        end
        else
        begin
            tick_reg <= tick_next;
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            for (int i = 0; i < NUM_SECTORS; i++)
            begin
                counts_reg[i] <= counts_next[i];
            end
        end
    end

    // history ring: read ahead of the next slot to be overwritten, forwarding this write
    always_ff @(posedge clk)
    begin
        if (sample && !win_write)
        begin
            hist_mem[wp_new] <= sector;
        end
        if (sample && !win_write && (wp_new == rd_addr))
        begin
            old_rd_reg <= sector;
        end
        else
        begin
            old_rd_reg <= hist_mem[rd_addr];
        end
    end

    // output register with skid stage
    always_comb
    begin
        pop         = out_valid_reg & ~out_stall;
        skid_to_out = skid_valid_reg & pop;
        load_out    = sample && !skid_valid_reg && (!out_valid_reg || pop);
        load_skid   = sample && !skid_valid_reg && out_valid_reg && !pop;

        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (sample)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = load_skid;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_to_out)
        begin
            out_raw_reg  <= skid_raw_reg;
            out_filt_reg <= skid_filt_reg;
            out_head_reg <= skid_head_reg;
            out_elap_reg <= skid_elap_reg;
        end
        else if (load_out)
        begin
            out_raw_reg  <= sector;
            out_filt_reg <= best;
            out_head_reg <= HEADING_TAB[sector];
            out_elap_reg <= elapsed;
        end
        if (load_skid)
        begin
            skid_raw_reg  <= sector;
            skid_filt_reg <= best;
            skid_head_reg <= HEADING_TAB[sector];
            skid_elap_reg <= elapsed;
        end
    end

    assign out_valid        = out_valid_reg;
    assign raw_sector       = out_raw_reg;
    assign filtered_sector  = out_filt_reg;
    assign heading_half_deg = out_head_reg;
    assign elapsed_ticks    = out_elap_reg;

`ifndef SYNTH
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_counts_match_window: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(counts_reg[0]) + 32'(counts_reg[1]) + 32'(counts_reg[2]) + 32'(counts_reg[3])
         + 32'(counts_reg[4]) + 32'(counts_reg[5]) + 32'(counts_reg[6])
         + 32'(counts_reg[7])) == 32'(eff_len))
        else $error("sector counts do not add up to the window length");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= eff_len)
        else $error("fill count exceeds the window length");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(wp_reg) < eff_len)
        else $error("write position outside the window");

    a_sample_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample |=> out_valid_reg)
        else $error("sampling tick left no result");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_compass_sector_mode_filter.sv -----
`timescale 1ns / 1ps

module tb_compass_sector_mode_filter;
    import csmf_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped index, writes are dropped
    localparam int unsigned RING_DEPTH = HIST_DEPTH_DEF;

    typedef struct {
        logic [SECTOR_W-1:0]   raw_sector;
        logic [SECTOR_W-1:0]   filtered_sector;
        logic [HEADING_W-1:0]  heading_half_deg;
        logic [INTERVAL_W-1:0] elapsed_ticks;
    } heading_result_t;

    class heading_scoreboard;
        logic [INTERVAL_W-1:0] interval;
        logic [WINDOW_W-1:0]   win;
        logic [OFFSET_W-1:0]   offs;
        int unsigned           ticks;
        logic [SECTOR_W-1:0]   ring [RING_DEPTH];
        int unsigned           wpos;
        int unsigned           tally [NUM_SECTORS];
        heading_result_t       pending [$];
        int unsigned           errors;

        function new();
            errors = 0;
            interval = 16'd100;
            win = 7'd64;
            offs = 3'd3;
            ticks = 0;
            clear_window();
        endfunction

        function int unsigned window_depth();
            int unsigned n;
            n = 32'(win);
            if (n == 0)
            begin
                n = 1;
            end
            if (n > RING_DEPTH)
            begin
                n = RING_DEPTH;
            end
            return n;
        endfunction

        function void clear_window();
            foreach (ring[i])
            begin
                ring[i] = '0;
            end
            foreach (tally[i])
            begin
                tally[i] = 0;
            end
            wpos = 0;
            tally[0] = window_depth();
        endfunction

        function logic [SECTOR_W-1:0] pins_to_sector(input logic [2:0] code);
            case (code)
                3'd0: return 3'd4;
                3'd1: return 3'd3;
                3'd2: return 3'd1;
                3'd3: return 3'd2;
                3'd4: return 3'd5;
                3'd5: return 3'd6;
                3'd6: return 3'd0;
                default: return 3'd7;
            endcase
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] d);
            if (idx == REG_INTERVAL)
            begin
                interval = d[INTERVAL_W-1:0];
            end
            else if (idx == REG_WINDOW)
            begin
                win = d[WINDOW_W-1:0];
                clear_window();
            end
            else if (idx == REG_OFFSET)
            begin
                offs = d[OFFSET_W-1:0];
            end
        endfunction

        // pins = {pin0, pin1, pin2}
        function void note_tick(input logic [2:0] pins);
            int unsigned     elapsed;
            int unsigned     len;
            int unsigned     best;
            logic [2:0]      sec;
            logic [2:0]      old;
            heading_result_t r;
            elapsed = ticks + 1;
            if (elapsed > 65535)
            begin
                elapsed = 65535;
            end
            if (elapsed < 32'(interval))
            begin
                ticks = elapsed;
                return;
            end
            ticks = 0;
            sec = pins_to_sector(pins) + offs;
            len = window_depth();
            wpos = wpos + 1;
            if (wpos >= len)
            begin
                wpos = 0;
            end
            old = ring[wpos];
            if (tally[old] > 0)
            begin
                tally[old] = tally[old] - 1;
            end
            ring[wpos] = sec;
            tally[sec] = tally[sec] + 1;
            // strict greater-than keeps the lowest sector on a tie
            best = 0;
            for (int i = 1; i < NUM_SECTORS; i++)
            begin
                if (tally[i] > tally[best])
                begin
                    best = 32'(i);
                end
            end
            r.raw_sector = sec;
            r.filtered_sector = best[SECTOR_W-1:0];
            r.heading_half_deg = HEADING_W'(int'(sec) * 90 + 45);
            r.elapsed_ticks = elapsed[INTERVAL_W-1:0];
            pending.push_back(r);
        endfunction

        function void cmp_field(input string name, input int unsigned e, input int unsigned a);
            if (e != a)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(input heading_result_t a);
            heading_result_t e;
            if (pending.size() == 0)
            begin
                $error("result transaction with nothing expected: raw %0d filtered %0d",
                       a.raw_sector, a.filtered_sector);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp_field("raw_sector", 32'(e.raw_sector), 32'(a.raw_sector));
            cmp_field("filtered_sector", 32'(e.filtered_sector), 32'(a.filtered_sector));
            cmp_field("heading_half_deg", 32'(e.heading_half_deg), 32'(a.heading_half_deg));
            cmp_field("elapsed_ticks", 32'(e.elapsed_ticks), 32'(a.elapsed_ticks));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  pin0_level;
    logic                  pin1_level;
    logic                  pin2_level;
    logic                  out_valid;
    logic                  out_stall;
    logic [SECTOR_W-1:0]   raw_sector;
    logic [SECTOR_W-1:0]   filtered_sector;
    logic [HEADING_W-1:0]  heading_half_deg;
    logic [INTERVAL_W-1:0] elapsed_ticks;

    heading_scoreboard sb;
    bit                idle_on;
    int unsigned       stall_left;

    compass_sector_mode_filter uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .pin0_level       (pin0_level),
        .pin1_level       (pin1_level),
        .pin2_level       (pin2_level),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .raw_sector       (raw_sector),
        .filtered_sector  (filtered_sector),
        .heading_half_deg (heading_half_deg),
        .elapsed_ticks    (elapsed_ticks)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure in bursts
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            stall_left <= 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        heading_result_t r;
        if (rst_n && out_valid && !out_stall)
        begin
            r.raw_sector = raw_sector;
            r.filtered_sector = filtered_sector;
            r.heading_half_deg = heading_half_deg;
            r.elapsed_ticks = elapsed_ticks;
            sb.check_result(r);
        end
    end

    task automatic send_tick(input logic [2:0] pins);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 8);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        pin0_level <= pins[2];
        pin1_level <= pins[1];
        pin2_level <= pins[0];
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_tick(pins);
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // junk in the upper data bits must be ignored
    task automatic write_window(input logic [WINDOW_W-1:0] wl);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom_range(0, 65535));
        d[WINDOW_W-1:0] = wl;
        write_cfg(REG_WINDOW, d);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] o);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom_range(0, 65535));
        d[OFFSET_W-1:0] = o;
        write_cfg(REG_OFFSET, d);
    endtask

    task automatic run_phase(input int unsigned n, input int unsigned bias, input bit hold);
        logic [2:0] fav;
        fav = 3'($urandom_range(0, 7));
        for (int i = 0; i < n; i++)
        begin
            if (hold && i == n / 2)
            begin
                drain();
            end
            if ($urandom_range(0, 99) < bias)
            begin
                send_tick(fav);
            end
            else
            begin
                send_tick(3'($urandom_range(0, 7)));
            end
        end
        drain();
    endtask

    initial
    begin
        #5_000_000;
        $display("** compass_sector_mode_filter: FAILED **");
        $finish;
    end

    initial
    begin
        logic [WINDOW_W-1:0] wl;
        int unsigned         pick;
        sb = new();
        idle_on = 1'b0;
        stall_left = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pin0_level = 1'b0;
        pin1_level = 1'b0;
        pin2_level = 1'b0;
        out_stall = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: one sample after 100 ticks
        idle_on = 1'b1;
        run_phase(100, 0, 1'b0);

        // every pin code with no rotation, then a rotation by seven sectors
        write_cfg(REG_INTERVAL, 16'd1);
        write_offset(3'd0);
        write_window(7'd64);
        for (int c = 0; c < 8; c++)
        begin
            send_tick(3'(c));
        end
        drain();
        write_offset(3'd7);
        write_cfg(REG_SPARE, 16'hFFFF);
        send_tick(3'd0);
        send_tick(3'd7);
        drain();
        // zero interval and zero window both act as one
        write_cfg(REG_INTERVAL, 16'd0);
        write_window(7'd0);
        send_tick(3'd5);
        send_tick(3'd2);
        drain();
        // window above the ring depth, then a lowered interval mid-count
        write_window(7'd127);
        write_cfg(REG_INTERVAL, 16'd30);
        for (int i = 0; i < 10; i++)
        begin
            send_tick(3'd6);
        end
        drain();
        write_cfg(REG_INTERVAL, 16'd5);
        send_tick(3'd3);
        drain();

        // longest interval counts on without sampling until it is lowered
        idle_on = 1'b0;
        write_cfg(REG_INTERVAL, 16'hFFFF);
        write_window(7'd1);
        run_phase(40, 50, 1'b0);
        write_cfg(REG_INTERVAL, 16'd7);
        send_tick(3'd4);
        drain();
        idle_on = 1'b1;

        for (int p = 0; p < 8; p++)
        begin
            if (p >= 6)
            begin
                idle_on = 1'b0;
            end
            pick = $urandom_range(0, 3);
            if (pick == 0)
            begin
                write_cfg(REG_INTERVAL, 16'($urandom_range(4, 40)));
            end
            else
            begin
                write_cfg(REG_INTERVAL, 16'($urandom_range(0, 3)));
            end
            case ($urandom_range(0, 4))
                0: wl = 7'd1;
                1: wl = 7'd64;
                2: wl = 7'($urandom_range(2, 8));
                3: wl = 7'($urandom_range(65, 127));
                default: wl = 7'($urandom_range(0, 63));
            endcase
            write_window(wl);
            write_offset(3'($urandom_range(0, 7)));
            run_phase(185, $urandom_range(20, 80), p == 2);
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("** compass_sector_mode_filter: PASSED **");
        end
        else
        begin
            $display("** compass_sector_mode_filter: FAILED **");
        end
        $finish;
    end

endmodule
